/* sv/graph_walk_count_engine_assert.svh */
// Assertion macros shared by the graph walk count engine modules.
`ifndef GRAPH_WALK_COUNT_ENGINE_ASSERT_SVH
`define GRAPH_WALK_COUNT_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define GWCE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle rule violated");
`define GWCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle rule violated");
`else
`define GWCE_ASSERT_SAME(lbl, ante, cons)
`define GWCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/gwce_pkg.sv */
// Package with types, constants and helpers of the graph walk count engine.
package gwce_pkg;

  localparam int MAX_VERTICES_DEF    = 128;
  localparam int MAX_WALK_LENGTH_DEF = 10;
  localparam int NODE_W  = 7;
  localparam int CFG_W   = 8;
  localparam int LEN_W   = 4;
  localparam int COUNT_W = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]   walk_length;
    logic [COUNT_W-1:0] walk_count;
    logic [COUNT_W-1:0] closed_walk_count;
    logic               saturated;
    logic               last;
  } out_item_t;

  // Control of the adjacency row memory.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } adj_ctl_t;

  // Control of one walk matrix memory.
  typedef struct packed {
    logic rd;
    logic wr;
  } ram_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_E_RDA,
    S_E_WRA,
    S_E_RDB,
    S_E_WRB,
    S_I_RD,
    S_I_WR,
    S_M_ROW,
    S_M_ACC,
    S_M_DRAIN,
    S_M_STORE,
    S_EMIT
  } state_t;

  // Saturating unsigned 64-bit addition.
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

/* sv/gwce_adj_mem.sv */
// Adjacency row memory with one valid bit per row for instant clearing.
module gwce_adj_mem
  import gwce_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  adj_ctl_t                        ctl,
  input  logic [$clog2(MAX_VERTICES)-1:0] addr,
  input  logic [MAX_VERTICES-1:0]         wdata,
  output logic [MAX_VERTICES-1:0]         row
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vld_r;
  logic [MAX_VERTICES-1:0] q_r;
  logic                    qv_r;

  // Row storage, written and read through one port.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      q_r <= mem[addr];
    end
  end

  // Row valid bits; a row never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.rd) begin
        qv_r <= vld_r[addr];
      end
    end
  end

  assign row = qv_r ? q_r : '0;

endmodule

/* sv/gwce_walk_ram.sv */
// Walk matrix memory: 64-bit entries, one write and one registered read port.
module gwce_walk_ram
  import gwce_pkg::*;
#(
  parameter int AW = 14
) (
  input  logic               clk,
  input  ram_ctl_t           ctl,
  input  logic [AW-1:0]      raddr,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] wdata,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [1 << AW];
  logic [COUNT_W-1:0] q_r;

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      q_r <= mem[raddr];
    end
  end

  assign rdata = q_r;

endmodule

/* sv/graph_walk_count_engine.sv */
// Top level of the graph walk count engine: sequencer, datapath and memories.
//
// An edge transaction is accepted and then does two row read-modify-writes of
// the adjacency memory; an out-of-range edge is accepted and dropped. A finish
// transaction computes the walk matrix powers for n vertices in use and is held
// while the result side stalls: each product entry is a sum over n terms read
// one per cycle from the single read port of the walk matrix memory. Powers
// alternate between two walk memories. The adjacency is cleared through per-row
// valid bits when the last result is registered, so there is no clearing pass
// after reset.
module graph_walk_count_engine
  import gwce_pkg::*;
#(
  parameter int MAX_VERTICES    = MAX_VERTICES_DEF,
  parameter int MAX_WALK_LENGTH = MAX_WALK_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

`include "graph_walk_count_engine_assert.svh"

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int KW = $clog2(MAX_WALK_LENGTH + 1);
  localparam int AW = 2 * VW;
  localparam int CW = NW + NODE_W;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   vc_r;
  logic [NW-1:0]      n_act;
  logic [VW-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [VW-1:0]      i_r, i_nxt, j_r, j_nxt, kk_r, kk_nxt, kk_d_r;
  logic               pend_r;
  logic [COUNT_W-1:0] acc_r, acc_nxt, tot_r, tot_nxt, trc_r, trc_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic               bank_r, bank_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               accept, in_range, out_free;
  logic               i_last, j_last, kk_last, k_last;
  logic [COUNT_W-1:0] wr_val, rd_val, term;

  adj_ctl_t                adj_ctl;
  logic [VW-1:0]           adj_addr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_row;
  ram_ctl_t                walk_ctl, ctl0, ctl1;
  logic [AW-1:0]           walk_raddr, walk_waddr;
  logic [COUNT_W-1:0]      walk_wdata, q0, q1;

  // Memories.
  gwce_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
    .clk(clk), .rst_n(rst_n), .ctl(adj_ctl), .addr(adj_addr),
    .wdata(adj_wdata), .row(adj_row)
  );

  gwce_walk_ram #(.AW(AW)) u_walk0 (
    .clk(clk), .ctl(ctl0), .raddr(walk_raddr), .waddr(walk_waddr),
    .wdata(walk_wdata), .rdata(q0)
  );

  gwce_walk_ram #(.AW(AW)) u_walk1 (
    .clk(clk), .ctl(ctl1), .raddr(walk_raddr), .waddr(walk_waddr),
    .wdata(walk_wdata), .rdata(q1)
  );

  // Bank bit names the memory that holds the current power; writes go to the other.
  assign ctl0.rd = walk_ctl.rd && !bank_r;
  assign ctl1.rd = walk_ctl.rd && bank_r;
  assign ctl0.wr = walk_ctl.wr && bank_r;
  assign ctl1.wr = walk_ctl.wr && !bank_r;
  assign rd_val  = bank_r ? q1 : q0;

  // Handshakes and derived conditions.
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign n_act    = (9'(vc_r) > 9'(MAX_VERTICES)) ? '0 : NW'(vc_r);
  assign in_range = (CW'(in_data.node_a) < CW'(n_act)) &&
                    (CW'(in_data.node_b) < CW'(n_act));
  assign i_last   = (NW'(i_r) + NW'(1)) == n_act;
  assign j_last   = (NW'(j_r) + NW'(1)) == n_act;
  assign kk_last  = (NW'(kk_r) + NW'(1)) == n_act;
  assign k_last   = (k_r == KW'(MAX_WALK_LENGTH));
  assign term     = adj_row[kk_d_r] ? rd_val : '0;
  assign wr_val   = (state_r == S_I_WR) ? COUNT_W'(adj_row[j_r]) : acc_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_FINISH) begin
            state_nxt = (n_act == '0) ? S_EMIT : S_I_RD;
          end else if (in_range) begin
            state_nxt = S_E_RDA;
          end
        end
      end
      S_E_RDA:   state_nxt = S_E_WRA;
      S_E_WRA:   state_nxt = S_E_RDB;
      S_E_RDB:   state_nxt = S_E_WRB;
      S_E_WRB:   state_nxt = S_IDLE;
      S_I_RD:    state_nxt = S_I_WR;
      S_I_WR: begin
        if (j_last) begin
          state_nxt = i_last ? S_EMIT : S_I_RD;
        end
      end
      S_M_ROW:   state_nxt = S_M_ACC;
      S_M_ACC: begin
        if (kk_last) begin
          state_nxt = S_M_DRAIN;
        end
      end
      S_M_DRAIN: state_nxt = S_M_STORE;
      S_M_STORE: state_nxt = (j_last && i_last) ? S_EMIT : S_M_ROW;
      S_EMIT: begin
        if (out_free) begin
          if (k_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = (n_act == '0) ? S_EMIT : S_M_ROW;
          end
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Memory controls per state.
  always_comb begin
    adj_ctl    = '0;
    adj_addr   = i_r;
    adj_wdata  = adj_row;
    walk_ctl   = '0;
    walk_raddr = {i_r, kk_r};
    walk_waddr = {i_r, j_r};
    walk_wdata = wr_val;
    unique case (state_r)
      S_E_RDA: begin
        adj_ctl.rd = 1'b1;
        adj_addr   = a_r;
      end
      S_E_WRA: begin
        adj_ctl.wr = 1'b1;
        adj_addr   = a_r;
        adj_wdata  = adj_row | (MAX_VERTICES'(1) << b_r);
      end
      S_E_RDB: begin
        adj_ctl.rd = 1'b1;
        adj_addr   = b_r;
      end
      S_E_WRB: begin
        adj_ctl.wr = 1'b1;
        adj_addr   = b_r;
        adj_wdata  = adj_row | (MAX_VERTICES'(1) << a_r);
      end
      S_I_RD: begin
        adj_ctl.rd = 1'b1;
      end
      S_I_WR: begin
        walk_ctl.wr = 1'b1;
      end
      S_M_ROW: begin
        adj_ctl.rd = 1'b1;
        adj_addr   = j_r;
      end
      S_M_ACC: begin
        walk_ctl.rd = 1'b1;
      end
      S_M_STORE: begin
        walk_ctl.wr = 1'b1;
      end
      S_EMIT: begin
        adj_ctl.clr = out_free && k_last;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kk_nxt        = kk_r;
    tot_nxt       = tot_r;
    trc_nxt       = trc_r;
    k_nxt         = k_r;
    bank_nxt      = bank_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    acc_nxt       = pend_r ? sat_add(acc_r, term) : acc_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt   = VW'(in_data.node_a);
          b_nxt   = VW'(in_data.node_b);
          i_nxt   = '0;
          j_nxt   = '0;
          k_nxt   = KW'(1);
          tot_nxt = '0;
          trc_nxt = '0;
        end
      end
      S_I_WR, S_M_STORE: begin
        tot_nxt = sat_add(tot_r, wr_val);
        trc_nxt = (i_r == j_r) ? sat_add(trc_r, wr_val) : trc_r;
        if (j_last) begin
          j_nxt = '0;
          i_nxt = i_r + VW'(1);
        end else begin
          j_nxt = j_r + VW'(1);
        end
      end
      S_M_ROW: begin
        kk_nxt  = '0;
        acc_nxt = '0;
      end
      S_M_ACC: begin
        if (!kk_last) begin
          kk_nxt = kk_r + VW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.walk_length       = LEN_W'(k_r);
          out_data_nxt.walk_count        = tot_r;
          out_data_nxt.closed_walk_count = trc_r;
          out_data_nxt.saturated         = (tot_r == COUNT_MAX) || (trc_r == COUNT_MAX);
          out_data_nxt.last              = k_last;
          k_nxt    = k_r + KW'(1);
          bank_nxt = !bank_r;
          tot_nxt  = '0;
          trc_nxt  = '0;
          i_nxt    = '0;
          j_nxt    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= '0;
      pend_r      <= 1'b0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= (state_r == S_M_ACC);
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vc_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    kk_r       <= kk_nxt;
    kk_d_r     <= kk_r;
    acc_r      <= acc_nxt;
    tot_r      <= tot_nxt;
    trc_r      <= trc_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks on the sequencer.
  `GWCE_ASSERT_SAME(a_adj_wr_clr, adj_ctl.wr, !adj_ctl.clr)
  `GWCE_ASSERT_SAME(a_walk_wr_state, walk_ctl.wr, (state_r == S_I_WR) || (state_r == S_M_STORE))
  `GWCE_ASSERT_SAME(a_pend_state, pend_r, (state_r == S_M_ACC) || (state_r == S_M_DRAIN))
  `GWCE_ASSERT_NEXT(a_last_idle, (state_r == S_EMIT) && out_free && k_last, (state_r == S_IDLE) && out_valid_r && out_data_r.last)
  `GWCE_ASSERT_SAME(a_last_clr, (state_r == S_EMIT) && out_free && k_last, adj_ctl.clr)

endmodule
